@@ rtl/rv32i_instruction_decoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_unit_macros.svh
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RVDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvdec check failed");

// next-cycle implication, checked out of reset
`define RVDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvdec check failed");

`endif

@@ rtl/rvdec_pkg.sv @@
// ----------------------------------------------------------------------------
// rvdec_pkg
// Opcodes, format, instruction and ALU codes and lookup functions for the
// RV32I decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvdec_pkg;

  localparam logic [6:0] ALT_FUNC_SEVEN = 7'h20;

  typedef enum logic [6:0] {
    OPC_LOAD   = 7'h03,
    OPC_OPIMM  = 7'h13,
    OPC_AUIPC  = 7'h17,
    OPC_STORE  = 7'h23,
    OPC_OP     = 7'h33,
    OPC_LUI    = 7'h37,
    OPC_BRANCH = 7'h63,
    OPC_JALR   = 7'h67,
    OPC_JAL    = 7'h6F
  } opcode_t;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_R    = 3'd1,
    FMT_I    = 3'd2,
    FMT_S    = 3'd3,
    FMT_B    = 3'd4,
    FMT_U    = 3'd5,
    FMT_J    = 3'd6
  } fmt_t;

  typedef enum logic [3:0] {
    ALU_NOP  = 4'd0,
    ALU_ADD  = 4'd1,
    ALU_SUB  = 4'd2,
    ALU_AND  = 4'd3,
    ALU_OR   = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_SLL  = 4'd6,
    ALU_SRL  = 4'd7,
    ALU_SRA  = 4'd8,
    ALU_SLT  = 4'd9,
    ALU_LTU  = 4'd10
  } alu_t;

  typedef enum logic [5:0] {
    ID_NONE  = 6'd0,
    ID_ADD   = 6'd1,
    ID_SUB   = 6'd2,
    ID_AND   = 6'd3,
    ID_OR    = 6'd4,
    ID_XOR   = 6'd5,
    ID_SLL   = 6'd6,
    ID_SRL   = 6'd7,
    ID_SRA   = 6'd8,
    ID_SLT   = 6'd9,
    ID_SLTU  = 6'd10,
    ID_ADDI  = 6'd11,
    ID_ANDI  = 6'd12,
    ID_ORI   = 6'd13,
    ID_XORI  = 6'd14,
    ID_SLTI  = 6'd15,
    ID_SLTIU = 6'd16,
    ID_SLLI  = 6'd17,
    ID_SRLI  = 6'd18,
    ID_SRAI  = 6'd19,
    ID_LB    = 6'd20,
    ID_LH    = 6'd21,
    ID_LW    = 6'd22,
    ID_LBU   = 6'd23,
    ID_LHU   = 6'd24,
    ID_SB    = 6'd25,
    ID_SH    = 6'd26,
    ID_SW    = 6'd27,
    ID_BEQ   = 6'd28,
    ID_BNE   = 6'd29,
    ID_BLT   = 6'd30,
    ID_BGE   = 6'd31,
    ID_BLTU  = 6'd32,
    ID_BGEU  = 6'd33,
    ID_LUI   = 6'd34,
    ID_AUIPC = 6'd35,
    ID_JAL   = 6'd36,
    ID_JALR  = 6'd37
  } id_t;

  function automatic alu_t alu_of_f3(input logic [2:0] f3);
    alu_t r;
    case (f3)
      3'd0:    r = ALU_ADD;
      3'd1:    r = ALU_SLL;
      3'd2:    r = ALU_SLT;
      3'd3:    r = ALU_LTU;
      3'd4:    r = ALU_XOR;
      3'd5:    r = ALU_SRL;
      3'd6:    r = ALU_OR;
      default: r = ALU_AND;
    endcase
    return r;
  endfunction

  function automatic id_t op_id(input logic [2:0] f3);
    id_t r;
    case (f3)
      3'd0:    r = ID_ADD;
      3'd1:    r = ID_SLL;
      3'd2:    r = ID_SLT;
      3'd3:    r = ID_SLTU;
      3'd4:    r = ID_XOR;
      3'd5:    r = ID_SRL;
      3'd6:    r = ID_OR;
      default: r = ID_AND;
    endcase
    return r;
  endfunction

  function automatic id_t opimm_id(input logic [2:0] f3);
    id_t r;
    case (f3)
      3'd0:    r = ID_ADDI;
      3'd1:    r = ID_SLLI;
      3'd2:    r = ID_SLTI;
      3'd3:    r = ID_SLTIU;
      3'd4:    r = ID_XORI;
      3'd5:    r = ID_SRLI;
      3'd6:    r = ID_ORI;
      default: r = ID_ANDI;
    endcase
    return r;
  endfunction

  function automatic id_t load_id(input logic [2:0] f3);
    id_t r;
    case (f3)
      3'd0:    r = ID_LB;
      3'd1:    r = ID_LH;
      3'd2:    r = ID_LW;
      3'd4:    r = ID_LBU;
      3'd5:    r = ID_LHU;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

  function automatic id_t store_id(input logic [2:0] f3);
    id_t r;
    case (f3)
      3'd0:    r = ID_SB;
      3'd1:    r = ID_SH;
      3'd2:    r = ID_SW;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

  function automatic id_t branch_id(input logic [2:0] f3);
    id_t r;
    case (f3)
      3'd0:    r = ID_BEQ;
      3'd1:    r = ID_BNE;
      3'd4:    r = ID_BLT;
      3'd5:    r = ID_BGE;
      3'd6:    r = ID_BLTU;
      3'd7:    r = ID_BGEU;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rv32i_instruction_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_unit
// Splits an RV32I word into its fields, classifies format, instruction and
// ALU operation, and builds the immediate (sign-extended; shift amounts zero-extended).
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | instr_word, instr_addr
//  result   | done (one cycle)   | addr_out .. is_valid
//
//  One word per cycle; busy never rises.
//  Pipeline: input register, then decode into result register.
//  rst clears the valid flags of both stages; payload registers are not reset.
//  The receiver cannot stall; every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instr_word,
  input  logic [31:0] instr_addr,
  output logic        done,
  output logic [31:0] addr_out,
  output logic [6:0]  major_op,
  output logic [4:0]  dest_reg,
  output logic [2:0]  func_three,
  output logic [4:0]  src_reg_one,
  output logic [4:0]  src_reg_two,
  output logic [6:0]  func_seven,
  output logic [2:0]  fmt_code,
  output logic [5:0]  instr_id,
  output logic [3:0]  alu_code,
  output logic [31:0] immediate,
  output logic        is_valid
);
  import rvdec_pkg::*;

  logic        in_valid;
  logic [31:0] word;
  logic [31:0] addr;

  logic [2:0]  f3;
  logic        alt;
  fmt_t        fmt_next;
  id_t         id_next;
  alu_t        alu_next;
  logic [31:0] imm_next;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    word <= instr_word;
    addr <= instr_addr;
  end

  assign f3  = word[14:12];
  assign alt = (word[31:25] == ALT_FUNC_SEVEN);

  assign imm_i  = {{20{word[31]}}, word[31:20]};
  assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u  = {word[31:12], 12'd0};
  assign imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign imm_sh = {27'd0, word[24:20]};

  always_comb begin
    fmt_next = FMT_NONE;
    id_next  = ID_NONE;
    alu_next = ALU_NOP;
    imm_next = 32'd0;
    case (word[6:0])
      OPC_OP: begin
        fmt_next = FMT_R;
        id_next  = op_id(f3);
        alu_next = alu_of_f3(f3);
        if (alt && f3 == 3'd0) begin
          id_next  = ID_SUB;
          alu_next = ALU_SUB;
        end
        if (alt && f3 == 3'd5) begin
          id_next  = ID_SRA;
          alu_next = ALU_SRA;
        end
      end
      OPC_OPIMM: begin
        fmt_next = FMT_I;
        id_next  = opimm_id(f3);
        alu_next = alu_of_f3(f3);
        imm_next = (f3 == 3'd1 || f3 == 3'd5) ? imm_sh : imm_i;
        if (alt && f3 == 3'd5) begin
          id_next  = ID_SRAI;
          alu_next = ALU_SRA;
        end
      end
      OPC_LOAD: begin
        fmt_next = FMT_I;
        id_next  = load_id(f3);
        imm_next = imm_i;
      end
      OPC_JALR: begin
        fmt_next = FMT_I;
        id_next  = (f3 == 3'd0) ? ID_JALR : ID_NONE;
        imm_next = imm_i;
      end
      OPC_STORE: begin
        fmt_next = FMT_S;
        id_next  = store_id(f3);
        imm_next = imm_s;
      end
      OPC_BRANCH: begin
        fmt_next = FMT_B;
        id_next  = branch_id(f3);
        imm_next = imm_b;
      end
      OPC_LUI: begin
        fmt_next = FMT_U;
        id_next  = ID_LUI;
        imm_next = imm_u;
      end
      OPC_AUIPC: begin
        fmt_next = FMT_U;
        id_next  = ID_AUIPC;
        imm_next = imm_u;
      end
      OPC_JAL: begin
        fmt_next = FMT_J;
        id_next  = ID_JAL;
        imm_next = imm_j;
      end
      default: begin
        fmt_next = FMT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    addr_out    <= addr;
    major_op    <= word[6:0];
    dest_reg    <= word[11:7];
    func_three  <= f3;
    src_reg_one <= word[19:15];
    src_reg_two <= word[24:20];
    func_seven  <= word[31:25];
    fmt_code    <= fmt_next;
    instr_id    <= id_next;
    alu_code    <= alu_next;
    immediate   <= imm_next;
    is_valid    <= (id_next != ID_NONE);
  end

`include "rv32i_instruction_decoder_unit_macros.svh"

  `RVDEC_ASSERT_NEXT(a_accept_to_result, clk, rst, start && !busy, ##1 done)
  `RVDEC_ASSERT_NOW(a_addr_through, clk, rst, done, addr_out == $past(instr_addr, 2))
  `RVDEC_ASSERT_NOW(a_unknown_quiet, clk, rst, done && fmt_code == FMT_NONE,
                    !is_valid && immediate == 32'd0 && alu_code == ALU_NOP)
  `RVDEC_ASSERT_NOW(a_alu_only_op, clk, rst, done && alu_code != ALU_NOP,
                    (major_op == OPC_OP || major_op == OPC_OPIMM) && is_valid)
  `RVDEC_ASSERT_NOW(a_r_no_imm, clk, rst, done && fmt_code == FMT_R,
                    immediate == 32'd0)

endmodule
